FILE: sv/ttg_pkg.sv
package ttg_pkg;
  localparam int CoordW = 32;
  localparam int DiffW  = 33;
  localparam int ProdW  = 66;
  localparam int MagW   = 65;
  localparam int NormW  = 31;
  localparam int SumW   = 64;
  localparam int RootW  = 32;
  localparam int OutW   = 16;
  localparam int QuotW  = 48;
  localparam int InBytes  = 48;
  localparam int OutBytes = 7;
  localparam logic [OutW-1:0] SatMax = 16'd32767;
endpackage

FILE: sv/triangle_tangent_generator_unit.sv
// Per-triangle tangent unit. Each s_axis transfer carries one gathered
// triangle: corners 0..2 as x,y,z, then the three v texture coordinates,
// all signed Q16.16, 32 bits each from the lowest bit. One result per
// triangle leaves on m_axis: tangent x, y, z as Q1.15 (saturated at 32767),
// then the degenerate flag. A new triangle is taken every cycle while the
// output is not stalled. Pipeline stages from input transfer to result:
// edges and deltas take one stage, the exact cross terms two, the common
// normalize shift one, the sum of squares two, the square root one stage per
// root bit (32), the three divisions one stage per quotient bit from 16 down
// to 1 (16, all three in parallel), and the output register one, which also
// settles quotient bit 0. A stall freezes the whole pipeline.
module triangle_tangent_generator_unit
  import ttg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // corner0_x, corner0_y, corner0_z, corner1_x .. corner2_z,
  // corner0_tex_v, corner1_tex_v, corner2_tex_v
  input  logic [InBytes*8-1:0]   s_axis_tdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tangent_x, tangent_y, tangent_z, degenerate, zero fill
  output logic [OutBytes*8-1:0]  m_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready
);
  localparam int NRoot = RootW;
  localparam int NDiv  = OutW;
  localparam int NSt   = 6 + NRoot + NDiv + 1;

  typedef struct packed {
    logic [2:0]              neg;
    logic                    degen;
    logic [2:0][NormW-1:0]   m;
  } side_t;

  logic         adv;
  logic [NSt-1:0] vld;

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[NSt-1];

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NSt-2:0], s_axis_tvalid};
  end

  // stage 0: edges and deltas
  logic signed [DiffW-1:0] e10 [3], e12 [3];
  logic signed [DiffW-1:0] d10, d12;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        e10[j] <= DiffW'($signed(s_axis_tdata[j*32 +: 32]))
                - DiffW'($signed(s_axis_tdata[(3+j)*32 +: 32]));
        e12[j] <= DiffW'($signed(s_axis_tdata[(6+j)*32 +: 32]))
                - DiffW'($signed(s_axis_tdata[(3+j)*32 +: 32]));
      end
      d10 <= DiffW'($signed(s_axis_tdata[9*32 +: 32]))
           - DiffW'($signed(s_axis_tdata[10*32 +: 32]));
      d12 <= DiffW'($signed(s_axis_tdata[11*32 +: 32]))
           - DiffW'($signed(s_axis_tdata[10*32 +: 32]));
    end
  end

  // stage 1: products
  logic signed [ProdW-1:0] pa [3], pb [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        pa[j] <= e10[j] * d12;
        pb[j] <= e12[j] * d10;
      end
    end
  end

  // stage 2: cross terms as sign and magnitude
  logic [MagW-1:0] tm [3];
  logic [2:0]      tneg;
  always_comb begin
    logic signed [ProdW:0] df;
    for (int j = 0; j < 3; j++) begin
      df = (ProdW+1)'(pa[j]) - (ProdW+1)'(pb[j]);
      tneg[j] = df[ProdW];
      tm[j]   = df[ProdW] ? MagW'(-df) : MagW'(df);
    end
  end
  logic [MagW-1:0] t2 [3];
  logic [2:0]      n2;
  always_ff @(posedge clk) begin
    if (adv) begin
      t2 <= tm;
      n2 <= tneg;
    end
  end

  // stage 3: common shift so the largest magnitude has 31 bits
  logic [MagW-1:0] orm;
  logic [6:0]      blen;
  always_comb begin
    orm = t2[0] | t2[1] | t2[2];
    blen = '0;
    for (int b = 0; b < MagW; b++) if (orm[b]) blen = 7'(b + 1);
  end
  side_t s3;
  always_ff @(posedge clk) begin
    if (adv) begin
      s3.neg   <= n2;
      s3.degen <= (blen == 7'd0);
      for (int j = 0; j < 3; j++) begin
        if (blen >= 7'd31)
          s3.m[j] <= NormW'(t2[j] >> (blen - 7'd31));
        else
          s3.m[j] <= NormW'(t2[j] << (7'd31 - blen));
      end
    end
  end

  // stage 4: squares
  logic [SumW-3:0] sq [3];
  side_t s4;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) sq[j] <= s3.m[j] * s3.m[j];
      s4 <= s3;
    end
  end

  // stage 5: sum
  logic [SumW-1:0] ssum;
  side_t s5;
  always_ff @(posedge clk) begin
    if (adv) begin
      ssum <= SumW'(sq[0]) + SumW'(sq[1]) + SumW'(sq[2]);
      s5 <= s4;
    end
  end

  // square root: one result bit per stage, restoring
  logic [SumW-1:0]  rr [NRoot+1];
  logic [RootW-1:0] rq [NRoot+1];
  side_t            rs [NRoot+1];
  assign rr[0] = ssum;
  assign rq[0] = '0;
  assign rs[0] = s5;
  for (genvar k = 0; k < NRoot; k++) begin : g_sqrt
    localparam int B = NRoot - 1 - k;
    logic [SumW+1:0] trial;
    logic [RootW-1:0] cand;
    assign cand  = rq[k] | (RootW'(1) << B);
    assign trial = (SumW+2)'(cand) * (SumW+2)'(cand);
    logic [SumW-1:0]  r_q;
    logic [RootW-1:0] q_q;
    side_t            s_q;
    always_ff @(posedge clk) begin
      if (adv) begin
        r_q <= rr[k];
        q_q <= (trial <= (SumW+2)'(rr[k])) ? cand : rq[k];
        s_q <= rs[k];
      end
    end
    assign rr[k+1] = r_q;
    assign rq[k+1] = q_q;
    assign rs[k+1] = s_q;
  end

  // divisions: numerator m*2^16+N over 2N, one quotient bit per stage
  logic [RootW:0]  dv [NDiv+1];
  logic [QuotW:0]  rem [NDiv+1][3];
  logic [QuotW:0]  num [NDiv+1][3];
  logic [OutW:0]   qt  [NDiv+1][3];
  logic [2:0]      dn  [NDiv+1];
  logic            dd  [NDiv+1];
  always_comb begin
    logic [RootW-1:0] nn;
    nn = (rq[NRoot] == '0) ? RootW'(1) : rq[NRoot];
    dv[0] = {nn, 1'b0};
    dn[0] = rs[NRoot].neg;
    dd[0] = rs[NRoot].degen;
    for (int j = 0; j < 3; j++) begin
      num[0][j] = (QuotW+1)'({rs[NRoot].m[j], 16'd0}) + (QuotW+1)'(nn);
      rem[0][j] = '0;
      qt[0][j]  = '0;
    end
  end
  for (genvar k = 0; k < NDiv; k++) begin : g_div
    // quotient bits 16 down to 1; bit 0 is settled after the loop
    localparam int B = OutW - k;
    logic [RootW:0] dv_q;
    logic [2:0]     dn_q;
    logic           dd_q;
    logic [QuotW:0] rem_q [3], num_q [3];
    logic [OutW:0]  qt_q  [3];
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_q <= dv[k];
        dn_q <= dn[k];
        dd_q <= dd[k];
        for (int j = 0; j < 3; j++) begin
          num_q[j] <= num[k][j];
          if ((num[k][j] >> B) >= (QuotW+1)'(dv[k]) + (rem[k][j] >> B)) begin
            rem_q[j] <= rem[k][j] + ((QuotW+1)'(dv[k]) << B);
            qt_q[j]  <= qt[k][j] | ((OutW+1)'(1) << B);
          end else begin
            rem_q[j] <= rem[k][j];
            qt_q[j]  <= qt[k][j];
          end
        end
      end
    end
    assign dv[k+1] = dv_q;
    assign dn[k+1] = dn_q;
    assign dd[k+1] = dd_q;
    for (genvar j = 0; j < 3; j++) begin : g_c
      assign rem[k+1][j] = rem_q[j];
      assign num[k+1][j] = num_q[j];
      assign qt[k+1][j]  = qt_q[j];
    end
  end

  // final stage: last quotient bit, saturate, sign, output register
  logic [OutW-1:0] res [3];
  logic            res_d;
  always_ff @(posedge clk) begin
    if (adv) begin
      res_d <= dd[NDiv];
      for (int j = 0; j < 3; j++) begin
        logic [OutW:0] q;
        q = qt[NDiv][j];
        if (num[NDiv][j] - rem[NDiv][j] >= (QuotW+1)'(dv[NDiv])) q = q | (OutW+1)'(1);
        if (q > (OutW+1)'(SatMax)) q = (OutW+1)'(SatMax);
        if (dd[NDiv]) res[j] <= '0;
        else res[j] <= dn[NDiv][j] ? OutW'(-q) : OutW'(q);
      end
    end
  end

  assign m_axis_tdata = {7'd0, res_d, res[2], res[1], res[0]};
endmodule

FILE: sv/ttg_checker.sv
module ttg_checker
  import ttg_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic [OutBytes*8-1:0] m_axis_tdata,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic                  s_axis_tready
);
  // a stalled output holds its data
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  // degenerate results carry zero components
  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[48] |-> m_axis_tdata[47:0] == 48'd0)
    else $error("degenerate result not zero");
  // input ready follows output backpressure
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("ready while stalled");
  // no result right after reset
  a_rst: assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !m_axis_tvalid)
    else $error("valid after reset");
endmodule

bind triangle_tangent_generator_unit ttg_checker u_ttg_checker (.*);

FILE: tb/ttg_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the tangent unit, predicts each result from the
// accepted triangle and compares it with what leaves the master side.
module ttg_scoreboard
  import ttg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [InBytes*8-1:0]   s_tdata,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [OutBytes*8-1:0]  m_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  output int                     errors,
  output int                     pending
);

  typedef struct packed {
    logic              degenerate;
    logic [OutW-1:0]   tz;
    logic [OutW-1:0]   ty;
    logic [OutW-1:0]   tx;
  } tangent_t;

  tangent_t tangent_q[$];

  initial errors = 0;
  assign pending = tangent_q.size();

  // Exact cross terms, common normalize shift, integer root, rounded divide.
  function automatic tangent_t compute_tangent(logic [InBytes*8-1:0] d);
    logic signed [31:0] c[12];
    longint e10[3], e12[3], d10, d12;
    logic signed [67:0] a, b, p, q, t[3];
    logic [67:0] mag[3];
    logic [63:0] m[3];
    logic [64:0] sum, root, trial, quo;
    logic [OutW-1:0] res[3];
    int maxlen, sh;
    tangent_t r;
    for (int k = 0; k < 12; k++) c[k] = d[k*32 +: 32];
    for (int j = 0; j < 3; j++) begin
      e10[j] = longint'(c[j]) - longint'(c[3+j]);
      e12[j] = longint'(c[6+j]) - longint'(c[3+j]);
    end
    d10 = longint'(c[9]) - longint'(c[10]);
    d12 = longint'(c[11]) - longint'(c[10]);
    maxlen = 0;
    for (int j = 0; j < 3; j++) begin
      a = e10[j];
      b = e12[j];
      p = d12;
      q = d10;
      t[j] = a * p - b * q;
      mag[j] = t[j] < 0 ? -t[j] : t[j];
      for (int k = 0; k < 68; k++) if (mag[j][k] && k + 1 > maxlen) maxlen = k + 1;
    end
    r = '0;
    if (maxlen == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    sh = maxlen - 31;
    sum = '0;
    for (int j = 0; j < 3; j++) begin
      m[j] = sh >= 0 ? 64'(mag[j] >> sh) : 64'(mag[j] << (-sh));
      sum += 65'(m[j]) * 65'(m[j]);
    end
    root = '0;
    for (int k = 31; k >= 0; k--) begin
      trial = root | (65'd1 << k);
      if (trial * trial <= sum) root = trial;
    end
    if (root == 0) root = 1;
    for (int j = 0; j < 3; j++) begin
      quo = ((65'(m[j]) << 16) + root) / (2 * root);
      if (quo > 65'(SatMax)) quo = 65'(SatMax);
      res[j] = t[j] < 0 ? -quo[OutW-1:0] : quo[OutW-1:0];
    end
    r.tx = res[0];
    r.ty = res[1];
    r.tz = res[2];
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    tangent_t want, got;
    if (!rst) begin
      // queue a prediction for each triangle transfer
      if (s_tvalid && s_tready) tangent_q = {tangent_q, compute_tangent(s_tdata)};
      // compare each result transfer with the oldest prediction
      if (m_tvalid && m_tready) begin
        got = m_tdata[3*OutW:0];
        if (tangent_q.size() == 0) begin
          report("unexpected result, tangent_x", $signed(got.tx), 0);
        end else begin
          want = tangent_q.pop_front();
          if (got.tx !== want.tx) report("tangent_x", $signed(got.tx), $signed(want.tx));
          if (got.ty !== want.ty) report("tangent_y", $signed(got.ty), $signed(want.ty));
          if (got.tz !== want.tz) report("tangent_z", $signed(got.tz), $signed(want.tz));
          if (got.degenerate !== want.degenerate)
            report("degenerate", got.degenerate, want.degenerate);
          if (m_tdata[OutBytes*8-1:3*OutW+1] !== '0)
            report("zero fill", m_tdata[OutBytes*8-1:3*OutW+1], 0);
        end
      end
    end
  end

endmodule

FILE: tb/triangle_tangent_generator_unit_tb.sv
`timescale 1ns / 1ps

module triangle_tangent_generator_unit_tb
  import ttg_pkg::*;
();

  localparam int NumRandom = 1200;
  localparam int IdleLimit = 5000;
  localparam int HoldCycles = 400;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [InBytes*8-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OutBytes*8-1:0] m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;

  int errors, pending;
  int sent = 0;
  int idle = 0;
  bit held = 0;

  triangle_tangent_generator_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  ttg_scoreboard u_scoreboard (
    .clk(clk), .rst(rst),
    .s_tdata(s_axis_tdata), .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
    .m_tdata(m_axis_tdata), .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
    .errors(errors), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'hffffffff;
      4: return 32'h1;
      default: return 32'h00010000;
    endcase
  endfunction

  // Offer one triangle and hold it until the transfer happens.
  task automatic send_triangle(logic [31:0] v[12], int gap);
    bit rdy;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    for (int k = 0; k < 12; k++) s_axis_tdata[k*32 +: 32] <= v[k];
    do begin
      @(negedge clk);
      rdy = s_axis_tready;
      @(posedge clk);
    end while (!rdy);
    sent++;
  endtask

  // Receiver: random ready with one long hold-off once the run is going.
  initial begin
    int k;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && sent >= 200) begin
        held = 1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        k = $urandom_range(0, 99);
        if (k < 55) begin
          m_axis_tready <= 1'b1;
          repeat ($urandom_range(1, 30)) @(posedge clk);
        end else if (k < 93) begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(10, 60)) @(posedge clk);
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle <= 0;
    end else if (idle >= IdleLimit) begin
      $display("timeout after %0d idle cycles", idle);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle <= idle + 1;
    end
  end

  initial begin
    logic [31:0] v[12];
    logic [31:0] base;
    int mode;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // all zero, all max, all min: degenerate
    v = '{default: 32'h0};
    send_triangle(v, 0);
    v = '{default: 32'h7fffffff};
    send_triangle(v, 0);
    v = '{default: 32'h80000000};
    send_triangle(v, 1);
    // tangent along one axis only: saturates, both signs
    v = '{default: 32'h0};
    v[0] = 32'h00010000; v[11] = 32'h00010000;
    send_triangle(v, 0);
    v[0] = 32'hffff0000;
    send_triangle(v, 0);
    // smallest nonzero tangent: magnitude shifted left
    v = '{default: 32'h0};
    v[1] = 32'h1; v[11] = 32'h1;
    send_triangle(v, 0);
    // equal texture coordinates: degenerate with distinct corners
    for (int k = 0; k < 9; k++) v[k] = $urandom;
    v[9] = 32'h1234; v[10] = 32'h1234; v[11] = 32'h1234;
    send_triangle(v, 2);
    // largest edges and deltas, opposite corners at the extremes
    v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
          32'h80000000, 32'h80000000, 32'h80000000,
          32'h7fffffff, 32'h80000000, 32'h7fffffff,
          32'h7fffffff, 32'h80000000, 32'h80000000};
    send_triangle(v, 0);
    v = '{32'h80000000, 32'h7fffffff, 32'h80000000,
          32'h7fffffff, 32'h80000000, 32'h7fffffff,
          32'h80000000, 32'h80000000, 32'h7fffffff,
          32'h80000000, 32'h7fffffff, 32'h7fffffff};
    send_triangle(v, 0);
    // random picks among the extremes
    repeat (14) begin
      for (int k = 0; k < 12; k++) v[k] = pick_extreme();
      send_triangle(v, pick_gap());
    end

    // random triangles of several shapes
    repeat (NumRandom) begin
      mode = $urandom_range(0, 99);
      base = $urandom;
      for (int k = 0; k < 12; k++) begin
        if (mode < 40) v[k] = $urandom;
        else if (mode < 65) v[k] = base + $urandom_range(0, 8191) - 4096;
        else if (mode < 80) v[k] = pick_extreme();
        else v[k] = base + ($urandom & 32'h000fffff);
      end
      // degenerate: equal texture coordinates or one corner repeated
      if (mode >= 90) begin
        if (mode & 1) begin
          v[10] = v[9]; v[11] = v[9];
        end else begin
          v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
          v[10] = v[9];
        end
      end
      send_triangle(v, pick_gap());
    end
    s_axis_tvalid <= 1'b0;

    // drain, then watch for stray results
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d triangles: extremes, degenerate and saturating cases, random shapes,",
             sent);
    $display("with random gaps on both sides and one long output hold-off");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/ttg_pkg.sv
sv/triangle_tangent_generator_unit.sv
sv/ttg_checker.sv
tb/ttg_checker.sv
tb/triangle_tangent_generator_unit_tb.sv
